### sv/assert_macros.svh
// assertion macros shared by the queue rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_IMPLY_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/llfq_pkg.sv
// shared constants for the linked-list queue with free stack
package llfq_pkg;

  localparam int CAP_W          = 11;
  localparam int WORD_W         = 32;
  localparam int POOL_DEPTH_DEF = 1024;
  localparam int CAPACITY_RESET = 1024;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

endpackage

### sv/llfq_pool.sv
// block pool: value and link memories with registered read
module llfq_pool
  import llfq_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [IW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_value,
  output logic [IW-1:0]     rd_next,
  input  logic              val_we,
  input  logic [IW-1:0]     val_addr,
  input  logic [WORD_W-1:0] val_data,
  input  logic              nxt_we,
  input  logic [IW-1:0]     nxt_addr,
  input  logic [IW-1:0]     nxt_data
);

  logic [WORD_W-1:0] value_mem [POOL_DEPTH];
  logic [IW-1:0]     next_mem  [POOL_DEPTH];
  logic [WORD_W-1:0] rd_value_r;
  logic [IW-1:0]     rd_next_r;

  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[val_addr] <= val_data;
    end
    if (rd_en) begin
      rd_value_r <= value_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      next_mem[nxt_addr] <= nxt_data;
    end
    if (rd_en) begin
      rd_next_r <= next_mem[rd_addr];
    end
  end

  assign rd_value = rd_value_r;
  assign rd_next  = rd_next_r;

endmodule

### sv/llfq_stack.sv
// free index stack memory with low-water mark standing in for a refill
module llfq_stack
  import llfq_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1,
  localparam int CW = $clog2(POOL_DEPTH + 1),
  localparam logic [CW-1:0] USED_RST = (CAPACITY_RESET > POOL_DEPTH) ?
                                       CW'(POOL_DEPTH) : CW'(CAPACITY_RESET)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          refill,
  input  logic [CW-1:0] refill_count,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic [IW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [IW-1:0] wr_data,
  input  logic          pop,
  input  logic [IW-1:0] pop_pos
);

  logic [IW-1:0] stack_mem [POOL_DEPTH];
  logic [IW-1:0] mem_q_r;
  logic [IW-1:0] rd_addr_r;
  // positions below the mark were never rewritten since refill and hold their own index
  logic [CW-1:0] mark_r;
  logic [CW-1:0] mark_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r   <= stack_mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_comb begin
    mark_nxt = mark_r;
    if (refill) begin
      mark_nxt = refill_count;
    end else if (pop && (CW'(pop_pos) < mark_r)) begin
      mark_nxt = CW'(pop_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= USED_RST;
    end else begin
      mark_r <= mark_nxt;
    end
  end

  assign rd_data = (CW'(rd_addr_r) < mark_r) ? rd_addr_r : mem_q_r;

endmodule

### sv/linked_list_fifo_with_free_stack_core.sv
// linked-list queue top: request sequencer over the block pool and free stack
// result: the request runs in the execute state after the accepting edge, then the result is registered
// a new request waits out the execute state, as the pool and stack memories have a registered read
// reset: queue empty, capacity min(1024, POOL_DEPTH), free stack holds 0 to capacity-1
// a capacity write re-empties the queue with no clearing pass
`include "assert_macros.svh"
module linked_list_fifo_with_free_stack_core
  import llfq_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1,
  localparam int CW = $clog2(POOL_DEPTH + 1),
  localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W,
  localparam logic [CW-1:0] USED_RST = (CAPACITY_RESET > POOL_DEPTH) ?
                                       CW'(POOL_DEPTH) : CW'(CAPACITY_RESET)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_mode,
  input  logic signed [WORD_W-1:0] in_write_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_ok,
  output logic signed [WORD_W-1:0] out_read_value,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CAP_W-1:0]         cfg_capacity
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic              state_r, state_nxt;
  logic              op_read_r, op_ok_r;
  logic [WORD_W-1:0] wval_r;
  logic [IW-1:0]     head_r, head_nxt;
  logic [IW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     fc_r, fc_nxt;
  logic [CW-1:0]     q_r, q_nxt;
  logic [CW-1:0]     used_r, used_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r;
  logic [WORD_W-1:0] out_val_r;

  logic              accept;
  logic              cfg_wr;
  logic [CW-1:0]     cap_used;
  logic [IW-1:0]     pop_pos;
  logic [IW-1:0]     stk_rd_data;
  logic              stk_wr_en;
  logic              stk_pop;
  logic [WORD_W-1:0] pool_value;
  logic [IW-1:0]     pool_next;
  logic              val_we, nxt_we;
  logic              do_exec;
  logic [CW:0]       fc_sum;

  // a pending capacity write holds off new requests
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall) || cfg_valid;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign cap_used = (CMP_W'(cfg_capacity) > CMP_W'(POOL_DEPTH)) ?
                    CW'(POOL_DEPTH) : CW'(cfg_capacity);

  // top of stack sits one below the free count
  assign pop_pos = IW'(fc_r - CW'(1));
  assign do_exec = (state_r == ST_EXEC) && op_ok_r;

  assign val_we    = do_exec && !op_read_r;
  assign nxt_we    = do_exec && !op_read_r && (q_r != '0);
  assign stk_pop   = do_exec && !op_read_r;
  assign stk_wr_en = do_exec && op_read_r;

  llfq_pool #(.POOL_DEPTH(POOL_DEPTH)) u_pool (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr  (head_r),
    .rd_value (pool_value),
    .rd_next  (pool_next),
    .val_we   (val_we),
    .val_addr (stk_rd_data),
    .val_data (wval_r),
    .nxt_we   (nxt_we),
    .nxt_addr (tail_r),
    .nxt_data (stk_rd_data)
  );

  llfq_stack #(.POOL_DEPTH(POOL_DEPTH)) u_stack (
    .clk          (clk),
    .rst_n        (rst_n),
    .refill       (cfg_wr),
    .refill_count (cap_used),
    .rd_en        (accept),
    .rd_addr      (pop_pos),
    .rd_data      (stk_rd_data),
    .wr_en        (stk_wr_en),
    .wr_addr      (fc_r[IW-1:0]),
    .wr_data      (head_r),
    .pop          (stk_pop),
    .pop_pos      (pop_pos)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fc_nxt        = fc_r;
    q_nxt         = q_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_wr) begin
          used_nxt = cap_used;
          fc_nxt   = cap_used;
          q_nxt    = '0;
          head_nxt = '0;
          tail_nxt = '0;
        end else if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        if (op_ok_r) begin
          if (op_read_r) begin
            head_nxt = pool_next;
            fc_nxt   = fc_r + CW'(1);
            q_nxt    = q_r - CW'(1);
          end else begin
            if (q_r == '0) begin
              head_nxt = stk_rd_data;
            end
            tail_nxt = stk_rd_data;
            fc_nxt   = fc_r - CW'(1);
            q_nxt    = q_r + CW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fc_r        <= USED_RST;
      q_r         <= '0;
      used_r      <= USED_RST;
      out_valid_r <= 1'b0;
      op_read_r   <= 1'b0;
      op_ok_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fc_r        <= fc_nxt;
      q_r         <= q_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        op_read_r <= (in_mode == MODE_READ);
        op_ok_r   <= (in_mode == MODE_READ) ? (q_r != '0)
                                            : ((fc_r != '0) && (q_r < used_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wval_r <= in_write_value;
    end
    if (state_r == ST_EXEC) begin
      out_ok_r  <= op_ok_r;
      out_val_r <= (op_read_r && op_ok_r) ? pool_value : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_val_r;

  assign fc_sum = {1'b0, fc_r} + {1'b0, q_r};

  `ASSERT_ALWAYS(a_count_balance, (fc_sum == {1'b0, used_r}), "free plus queued count differs from capacity")
  `ASSERT_IMPLY(a_out_slot_free, accept, (!out_valid_r || !out_stall), "request accepted while result slot stays occupied")
  `ASSERT_IMPLY_NEXT(a_exec_result, (state_r == ST_EXEC), out_valid_r, "executed request produced no result")

endmodule

### sim/linked_list_fifo_with_free_stack_core_tb.sv
// self-checking testbench for the linked-list queue with free stack
`timescale 1ns / 1ps
module linked_list_fifo_with_free_stack_core_tb;
  import llfq_pkg::*;

  localparam int POOL          = POOL_DEPTH_DEF;
  localparam int IDX_W         = $clog2(POOL);
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic              mode;
    logic [WORD_W-1:0] value;
  } queue_op_t;

  typedef struct {
    logic              ok;
    logic [WORD_W-1:0] value;
  } queue_reply_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_mode = MODE_WRITE;
  logic signed [WORD_W-1:0] in_write_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_ok;
  logic signed [WORD_W-1:0] out_read_value;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CAP_W-1:0]         cfg_capacity = '0;

  queue_op_t    pending_ops[$];
  queue_reply_t expected_replies[$];
  logic         in_fire = 1'b0;
  int           sender_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           idle_cycles = 0;
  int           mismatch_count = 0;

  // predicted queue state
  logic [CAP_W-1:0]  cap_setting;
  logic [WORD_W-1:0] blk_value [POOL];
  logic [IDX_W-1:0]  blk_link [POOL];
  logic [IDX_W-1:0]  free_idx [POOL];
  logic [CAP_W-1:0]  free_top;
  logic [CAP_W-1:0]  live_count;
  logic [IDX_W-1:0]  head_idx;
  logic [IDX_W-1:0]  tail_idx;

  linked_list_fifo_with_free_stack_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_write_value(in_write_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ok        (out_ok),
    .out_read_value(out_read_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_capacity  (cfg_capacity)
  );

  always #1 clk = ~clk;

  // capacity above the pool saturates to the pool depth
  function automatic int unsigned usable_blocks();
    return (cap_setting > POOL) ? POOL : cap_setting;
  endfunction

  function automatic void set_capacity(input logic [CAP_W-1:0] cap);
    cap_setting = cap;
    head_idx    = '0;
    tail_idx    = '0;
    live_count  = '0;
    for (int i = 0; i < usable_blocks(); i++) free_idx[i] = IDX_W'(i);
    free_top = CAP_W'(usable_blocks());
  endfunction

  function automatic queue_reply_t apply_queue_op(input queue_op_t op);
    queue_reply_t     r;
    logic [IDX_W-1:0] slot;
    r.ok    = 1'b0;
    r.value = '0;
    if (op.mode == MODE_WRITE) begin
      if (live_count < usable_blocks() && free_top > 0) begin
        free_top        = free_top - 1'b1;
        slot            = free_idx[free_top];
        blk_value[slot] = op.value;
        blk_link[slot]  = '0;
        if (live_count == 0) head_idx = slot;
        else blk_link[tail_idx] = slot;
        tail_idx   = slot;
        live_count = live_count + 1'b1;
        r.ok       = 1'b1;
      end
    end else if (live_count > 0 && free_top < POOL) begin
      r.value            = blk_value[head_idx];
      free_idx[free_top] = head_idx;
      free_top           = free_top + 1'b1;
      head_idx           = blk_link[head_idx];
      live_count         = live_count - 1'b1;
      r.ok               = 1'b1;
    end
    return r;
  endfunction

  function automatic void push_op(input logic mode, input logic [WORD_W-1:0] value);
    queue_op_t op;
    op.mode  = mode;
    op.value = value;
    pending_ops.push_back(op);
  endfunction

  // alternating write and read bursts with a little noise in the mode
  task automatic add_bursts(input int count, input int max_len);
    logic burst_mode;
    logic [WORD_W-1:0] v;
    int   left;
    int   len;
    burst_mode = MODE_WRITE;
    left       = count;
    while (left > 0) begin
      len = $urandom_range(max_len, 1);
      for (int j = 0; j < len && left > 0; j++) begin
        case ($urandom_range(15))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = '0;
          3: v = '1;
          default: v = $urandom();
        endcase
        if ($urandom_range(9) == 0) push_op(logic'($urandom_range(1)), v);
        else push_op(burst_mode, v);
        left--;
      end
      burst_mode = (burst_mode == MODE_WRITE) ? MODE_READ : MODE_WRITE;
    end
  endtask

  // wait until every request is accepted and every reply has come back
  task automatic drain_and_settle();
    do @(posedge clk);
    while (pending_ops.size() != 0 || in_valid || expected_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(negedge clk);
    cfg_valid    <= 1'b1;
    cfg_capacity <= cap;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic start_phase(input logic [CAP_W-1:0] cap, input int idle_pct,
                             input int stall_pct);
    drain_and_settle();
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    write_capacity(cap);
  endtask

  // request driver
  always @(negedge clk) begin
    queue_op_t op;
    if (!in_valid || in_fire) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        op = pending_ops.pop_front();
        in_valid       <= 1'b1;
        in_mode        <= op.mode;
        in_write_value <= op.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // monitor, checker and watchdog
  always @(posedge clk) begin
    queue_reply_t want;
    queue_op_t    op;
    if (!rst_n) begin
      in_fire     <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: reply with none expected: ok %0b value %0d",
                   $time, out_ok, out_read_value);
          mismatch_count++;
        end else begin
          want = expected_replies.pop_front();
          if (out_ok !== want.ok) begin
            $display("%0t: ok expected %0b actual %0b", $time, want.ok, out_ok);
            mismatch_count++;
          end
          if (out_read_value !== want.value) begin
            $display("%0t: read_value expected %0d actual %0d",
                     $time, $signed(want.value), out_read_value);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) set_capacity(cfg_capacity);
      if (in_valid && !in_stall) begin
        op.mode  = in_mode;
        op.value = in_write_value;
        expected_replies.push_back(apply_queue_op(op));
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("FAIL linked_list_fifo_with_free_stack_core");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    set_capacity(CAP_W'(CAPACITY_RESET));
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty read, value extremes, drain back to empty
    push_op(MODE_READ, 32'h1234_5678);
    push_op(MODE_WRITE, 32'h7fff_ffff);
    push_op(MODE_WRITE, 32'h8000_0000);
    push_op(MODE_WRITE, 32'h0000_0000);
    push_op(MODE_WRITE, 32'hffff_ffff);
    push_op(MODE_WRITE, 32'haaaa_aaaa);
    push_op(MODE_WRITE, 32'h5555_5555);
    repeat (7) push_op(MODE_READ, 32'hffff_ffff);

    // zero capacity: everything fails
    start_phase(11'd0, 0, 0);
    push_op(MODE_WRITE, 32'h0bad_cafe);
    push_op(MODE_READ, 32'h0);

    // single block: full and empty right away
    start_phase(11'd1, 0, 0);
    push_op(MODE_WRITE, 32'hffff_ffff);
    push_op(MODE_WRITE, 32'h0000_0005);
    push_op(MODE_READ, 32'h0);
    push_op(MODE_READ, 32'h0);

    start_phase(11'd2, 0, 0);
    add_bursts(40, 4);
    start_phase(11'd5, 67, 0);
    add_bursts(40, 7);
    start_phase(11'd1024, 0, 67);
    add_bursts(40, 24);
    start_phase(11'd3, 9, 9);
    add_bursts(40, 5);

    // capacity above the pool: fill every block, overflow, then mix
    start_phase(11'd2047, 0, 0);
    repeat (POOL + 2) push_op(MODE_WRITE, $urandom());
    add_bursts(20, 24);

    start_phase(11'd1, 9, 9);
    add_bursts(20, 3);

    drain_and_settle();
    if (mismatch_count == 0) begin
      $display("PASS linked_list_fifo_with_free_stack_core");
    end else begin
      $display("FAIL linked_list_fifo_with_free_stack_core");
    end
    $finish;
  end

endmodule
